>>> design/assert_macros.svh
// Assertion macros for the port checker of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRQ_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("srq: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRQ_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("srq: assertion failed");

`endif

>>> design/srq_pkg.sv
// Shared types, codes and constants of the sweep range qualifier.
// No dependencies; compiled first.
package srq_pkg;

  localparam int DIST_W    = 12;
  localparam int RUN_W     = 4;
  localparam int ANG_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_ANGLE_DEF  = 180;
  localparam int ANGLE_STEP_DEF = 2;

  localparam logic [RUN_W-1:0]  RUN_MAX = 4'hF;

  localparam logic [DIST_W-1:0] CLOSE_LIMIT_RST = 12'd80;
  localparam logic [DIST_W-1:0] BLIND_LIMIT_RST = 12'd20;
  localparam logic [DIST_W-1:0] MAX_RANGE_RST   = 12'd2500;
  localparam logic [DIST_W-1:0] WARN_LIMIT_RST  = 12'd300;
  localparam logic [RUN_W-1:0]  BLOCK_RUNS_RST  = 4'd3;
  localparam logic [RUN_W-1:0]  CLEAR_RUNS_RST  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSE_LIMIT = 3'd0,
    REG_BLIND_LIMIT = 3'd1,
    REG_MAX_RANGE   = 3'd2,
    REG_WARN_LIMIT  = 3'd3,
    REG_BLOCK_RUNS  = 3'd4,
    REG_CLEAR_RUNS  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_FRESH   = 2'd0,
    SRC_HISTORY = 2'd1,
    SRC_NONE    = 2'd2,
    SRC_IGNORED = 2'd3
  } src_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
  } srq_in_t;

  typedef struct packed {
    logic [ANG_W-1:0]  angle;
    logic [DIST_W-1:0] range_out;
    logic              warning;
    logic              blocked;
    logic              led_on;
    src_t              source;
  } srq_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIST_W-1:0]    value;
  } srq_cfg_t;

endpackage

>>> design/srq_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type comes from srq_pkg.
interface srq_chan_if #(
  parameter type payload_t = srq_pkg::srq_in_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/sweep_range_qualifier_top.sv
// Sweep range qualifier, top level.
// Depends on srq_pkg and srq_chan_if.
//
// One range reading enters per beat on in_if and one result beat leaves on out_if
// per reading; a new reading is taken every cycle unless out_if stalls, and each
// reading passes the input stage, then the result register. Each beat advances
// a ping-pong sweep by ANGLE_STEP degrees between 0 and MAX_ANGLE, runs the
// blockage qualifier (runs of close/blind vs. good readings), stores valid
// readings in a per-angle table and otherwise falls back to the stored value.
// The throughput is set by the table, a simple dual-port memory with one read
// and one write per cycle: the read for a reading is issued as it is accepted
// (the angle does not depend on data) and the write happens when that reading
// moves into the result register. A same-address write in the accept cycle is
// forwarded. The table starts all zero through per-entry valid bits cleared by
// reset, so no clearing pass is needed. Configuration writes on cfg_if are
// always accepted and must only be issued while the block holds no reading.
module sweep_range_qualifier_top #(
  parameter int MAX_ANGLE  = srq_pkg::MAX_ANGLE_DEF,
  parameter int ANGLE_STEP = srq_pkg::ANGLE_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srq_chan_if.sink    in_if,
  srq_chan_if.source  out_if,
  srq_chan_if.sink    cfg_if
);

  localparam int DEPTH = MAX_ANGLE + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int DW    = srq_pkg::DIST_W;
  localparam int RW    = srq_pkg::RUN_W;
  localparam int AW    = srq_pkg::ANG_W;

  localparam logic [AW:0]   MAX_ANG9 = (AW+1)'(MAX_ANGLE);
  localparam logic [AW-1:0] MAX_ANG  = AW'(MAX_ANGLE);
  localparam logic [AW-1:0] STEP     = AW'(ANGLE_STEP);

  // Configuration registers
  logic [DW-1:0] close_limit_r, blind_limit_r, max_range_r, warn_limit_r;
  logic [RW-1:0] block_runs_r, clear_runs_r;

  // Sweep position, advanced at input accept
  logic [AW-1:0] ang_r, ang_nxt;
  logic          down_r, down_nxt;
  logic [AW:0]   up_sum;

  // Input stage
  logic          s0_v_r;
  logic [DW-1:0] s0_dist_r;
  logic [AW-1:0] s0_ang_r;

  // Qualifier state
  logic [RW-1:0] close_run_r, close_run_nxt;
  logic [RW-1:0] good_run_r, good_run_nxt;
  logic          blk_r, blk_nxt;
  logic          led_r, led_nxt;

  // Result register
  logic              out_v_r;
  srq_pkg::srq_out_t out_r, out_nxt;

  // Table
  logic [DW-1:0]    tbl_mem_r [DEPTH];
  logic [DEPTH-1:0] tbl_vld_r;
  logic [DW-1:0]    rd_data_r, byp_data_r;
  logic             rd_vld_r, byp_r;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic             tbl_we;
  logic [DW-1:0]    stored;

  // Handshake
  logic in_acc, adv;

  assign adv          = s0_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !s0_v_r || adv;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  // Ping-pong sweep: saturate at the ends, turn once there.
  always_comb begin
    up_sum = {1'b0, ang_r} + {1'b0, STEP};
    if (!down_r) begin
      ang_nxt  = (up_sum >= MAX_ANG9) ? MAX_ANG : up_sum[AW-1:0];
      down_nxt = (ang_nxt == MAX_ANG);
    end else begin
      ang_nxt  = (ang_r > STEP) ? (ang_r - STEP) : '0;
      down_nxt = (ang_nxt != '0);
    end
  end

  assign rd_idx = ang_nxt[IDX_W-1:0];
  assign wr_idx = s0_ang_r[IDX_W-1:0];

  // Stored value for the reading in the input stage
  assign stored = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : '0);

  // Qualifier and result selection
  always_comb begin
    logic          near_hit, is_blind, in_win, ignore;
    logic [RW-1:0] need_block, need_clear, close_inc, good_inc;

    near_hit   = (s0_dist_r != '0) && (s0_dist_r < close_limit_r);
    is_blind   = s0_dist_r < blind_limit_r;
    in_win     = (s0_dist_r >= blind_limit_r) && (s0_dist_r <= max_range_r);
    need_block = (block_runs_r == '0) ? RW'(1) : block_runs_r;
    need_clear = (clear_runs_r == '0) ? RW'(1) : clear_runs_r;
    close_inc  = (close_run_r == srq_pkg::RUN_MAX) ? close_run_r : close_run_r + RW'(1);
    good_inc   = (good_run_r == srq_pkg::RUN_MAX) ? good_run_r : good_run_r + RW'(1);

    close_run_nxt = close_run_r;
    good_run_nxt  = good_run_r;
    blk_nxt       = blk_r;
    ignore        = 1'b0;

    if (near_hit || is_blind) begin
      if (blk_r) begin
        good_run_nxt = '0;
        ignore       = 1'b1;
      end else if (close_inc >= need_block) begin
        blk_nxt       = 1'b1;
        close_run_nxt = '0;
        good_run_nxt  = '0;
        ignore        = 1'b1;
      end else begin
        close_run_nxt = close_inc;
      end
    end else if (blk_r) begin
      ignore = 1'b1;
      if (good_inc >= need_clear) begin
        blk_nxt      = 1'b0;
        good_run_nxt = '0;
      end else begin
        good_run_nxt = good_inc;
      end
    end else begin
      close_run_nxt = '0;
    end

    tbl_we            = 1'b0;
    out_nxt.angle     = s0_ang_r;
    out_nxt.blocked   = blk_nxt;
    out_nxt.range_out = '0;
    out_nxt.warning   = 1'b0;
    led_nxt           = 1'b0;

    if (ignore) begin
      led_nxt         = !led_r;
      out_nxt.warning = 1'b1;
      out_nxt.source  = srq_pkg::SRC_IGNORED;
    end else if (in_win) begin
      tbl_we            = 1'b1;
      out_nxt.range_out = s0_dist_r;
      out_nxt.warning   = s0_dist_r < warn_limit_r;
      led_nxt           = out_nxt.warning;
      out_nxt.source    = srq_pkg::SRC_FRESH;
    end else if ((stored != '0) && (stored <= max_range_r)) begin
      out_nxt.range_out = stored;
      out_nxt.source    = srq_pkg::SRC_HISTORY;
    end else begin
      out_nxt.source = srq_pkg::SRC_NONE;
    end
    out_nxt.led_on = led_nxt;
  end

  // Table storage and registered read; write data forwarded on an address hit
  always_ff @(posedge clk) begin
    if (adv && tbl_we) begin
      tbl_mem_r[wr_idx] <= s0_dist_r;
    end
    if (in_acc) begin
      rd_data_r  <= tbl_mem_r[rd_idx];
      byp_data_r <= s0_dist_r;
    end
  end

  // Valid bits and read-side flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      if (adv && tbl_we) begin
        tbl_vld_r[wr_idx] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= tbl_vld_r[rd_idx];
        byp_r    <= adv && tbl_we && (wr_idx == rd_idx);
      end
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_limit_r <= srq_pkg::CLOSE_LIMIT_RST;
      blind_limit_r <= srq_pkg::BLIND_LIMIT_RST;
      max_range_r   <= srq_pkg::MAX_RANGE_RST;
      warn_limit_r  <= srq_pkg::WARN_LIMIT_RST;
      block_runs_r  <= srq_pkg::BLOCK_RUNS_RST;
      clear_runs_r  <= srq_pkg::CLEAR_RUNS_RST;
    end else if (cfg_if.valid) begin
      unique case (srq_pkg::cfg_reg_t'(cfg_if.data.index))
        srq_pkg::REG_CLOSE_LIMIT: close_limit_r <= cfg_if.data.value;
        srq_pkg::REG_BLIND_LIMIT: blind_limit_r <= cfg_if.data.value;
        srq_pkg::REG_MAX_RANGE:   max_range_r   <= cfg_if.data.value;
        srq_pkg::REG_WARN_LIMIT:  warn_limit_r  <= cfg_if.data.value;
        srq_pkg::REG_BLOCK_RUNS:  block_runs_r  <= cfg_if.data.value[RW-1:0];
        srq_pkg::REG_CLEAR_RUNS:  clear_runs_r  <= cfg_if.data.value[RW-1:0];
        default: ;
      endcase
    end
  end

  // Sweep, pipeline control and qualifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r       <= '0;
      down_r      <= 1'b0;
      s0_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      close_run_r <= '0;
      good_run_r  <= '0;
      blk_r       <= 1'b0;
      led_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        ang_r  <= ang_nxt;
        down_r <= down_nxt;
        s0_v_r <= 1'b1;
      end else if (adv) begin
        s0_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r     <= 1'b1;
        close_run_r <= close_run_nxt;
        good_run_r  <= good_run_nxt;
        blk_r       <= blk_nxt;
        led_r       <= led_nxt;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_dist_r <= in_if.data.distance;
      s0_ang_r  <= ang_nxt;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> design/srq_checker.sv
// Port-level checks for sweep_range_qualifier_top, attached by bind.
// Depends on srq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srq_port_checker #(
  parameter int MAX_ANGLE = srq_pkg::MAX_ANGLE_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input srq_pkg::srq_out_t out_data
);

  `SRQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `SRQ_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid, 32'(out_data.angle) <= 32'(MAX_ANGLE))
  `SRQ_ASSERT_IMP(a_ignored, clk, rst_n, out_valid && out_data.source == srq_pkg::SRC_IGNORED, out_data.warning && out_data.range_out == '0)
  `SRQ_ASSERT_IMP(a_none, clk, rst_n, out_valid && out_data.source == srq_pkg::SRC_NONE, out_data.range_out == '0 && !out_data.warning && !out_data.led_on)
  `SRQ_ASSERT_IMP(a_blocked_ign, clk, rst_n, out_valid && out_data.blocked, out_data.source == srq_pkg::SRC_IGNORED)

endmodule

bind sweep_range_qualifier_top srq_port_checker #(
  .MAX_ANGLE(MAX_ANGLE)
) u_srq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

>>> bench/srq_checker.sv
// Scoreboard for the sweep range qualifier: tracks register writes and readings,
// predicts each result beat and compares it with the result channel.
// Depends on srq_pkg.
module srq_checker import srq_pkg::*; #(
  parameter int MAX_ANGLE  = MAX_ANGLE_DEF,
  parameter int ANGLE_STEP = ANGLE_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  srq_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  srq_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  srq_cfg_t    cfg_data,
  output int unsigned mismatches,
  output int unsigned results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DIST_W-1:0] close_lim, blind_lim, max_rng, warn_lim;
  logic [RUN_W-1:0]  block_need, clear_need;

  int                sweep_pos;
  bit                sweeping_down;
  int                close_cnt, good_cnt;
  bit                is_blocked, led;
  logic [DIST_W-1:0] range_mem [0:MAX_ANGLE];
  srq_out_t          pending_results [$];

  // Advance the sweep, run the blockage qualifier and pick the reported range.
  function automatic srq_out_t qualify_reading(logic [DIST_W-1:0] d);
    srq_out_t r;
    bit       drop, near, blind;
    int       need_blk, need_clr, slot;
    if (!sweeping_down) begin
      sweep_pos = (sweep_pos + ANGLE_STEP >= MAX_ANGLE) ? MAX_ANGLE : sweep_pos + ANGLE_STEP;
      if (sweep_pos >= MAX_ANGLE) sweeping_down = 1'b1;
    end else begin
      sweep_pos = (sweep_pos > ANGLE_STEP) ? sweep_pos - ANGLE_STEP : 0;
      if (sweep_pos == 0) sweeping_down = 1'b0;
    end
    slot     = sweep_pos;
    near     = (d != '0) && (d < close_lim);
    blind    = d < blind_lim;
    need_blk = (block_need == '0) ? 1 : int'(block_need);
    need_clr = (clear_need == '0) ? 1 : int'(clear_need);
    drop     = 1'b0;
    if (near || blind) begin
      if (is_blocked) begin
        good_cnt = 0;
        drop     = 1'b1;
      end else begin
        if (close_cnt < int'(RUN_MAX)) close_cnt++;
        if (close_cnt >= need_blk) begin
          is_blocked = 1'b1;
          close_cnt  = 0;
          good_cnt   = 0;
          drop       = 1'b1;
        end
      end
    end else if (is_blocked) begin
      if (good_cnt < int'(RUN_MAX)) good_cnt++;
      if (good_cnt >= need_clr) begin
        is_blocked = 1'b0;
        good_cnt   = 0;
      end
      drop = 1'b1;
    end else begin
      close_cnt = 0;
    end

    r.range_out = '0;
    r.warning   = 1'b0;
    if (drop) begin
      led       = !led;
      r.warning = 1'b1;
      r.source  = SRC_IGNORED;
    end else if (d >= blind_lim && d <= max_rng) begin
      range_mem[slot] = d;
      r.range_out     = d;
      r.warning       = d < warn_lim;
      led             = r.warning;
      r.source        = SRC_FRESH;
    end else if (range_mem[slot] != '0 && range_mem[slot] <= max_rng) begin
      r.range_out = range_mem[slot];
      led         = 1'b0;
      r.source    = SRC_HISTORY;
    end else begin
      led      = 1'b0;
      r.source = SRC_NONE;
    end
    r.angle   = ANG_W'(sweep_pos);
    r.blocked = is_blocked;
    r.led_on  = led;
    return r;
  endfunction

  task automatic flag_beat(string what, srq_out_t want, srq_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t srq_checker: %s: exp ang %0d rng %0d warn %0b blk %0b led %0b src %0d, got ang %0d rng %0d warn %0b blk %0b led %0b src %0d",
               $time, what, want.angle, want.range_out, want.warning, want.blocked,
               want.led_on, want.source, got.angle, got.range_out, got.warning,
               got.blocked, got.led_on, got.source);
  endtask

  always @(posedge clk) begin
    srq_out_t want;
    if (!rst_n) begin
      close_lim     = CLOSE_LIMIT_RST;
      blind_lim     = BLIND_LIMIT_RST;
      max_rng       = MAX_RANGE_RST;
      warn_lim      = WARN_LIMIT_RST;
      block_need    = BLOCK_RUNS_RST;
      clear_need    = CLEAR_RUNS_RST;
      sweep_pos     = 0;
      sweeping_down = 1'b0;
      close_cnt     = 0;
      good_cnt      = 0;
      is_blocked    = 1'b0;
      led           = 1'b0;
      for (int i = 0; i <= MAX_ANGLE; i++) range_mem[i] = '0;
      pending_results.delete();
    end else begin
      // results first: latency keeps a beat from meeting its own reading
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_beat("unexpected result beat", '0, out_data);
        end else begin
          want = pending_results.pop_front();
          if (want.angle !== out_data.angle || want.range_out !== out_data.range_out ||
              want.warning !== out_data.warning || want.blocked !== out_data.blocked ||
              want.led_on !== out_data.led_on || want.source !== out_data.source)
            flag_beat("result mismatch", want, out_data);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_CLOSE_LIMIT: close_lim  = cfg_data.value;
          REG_BLIND_LIMIT: blind_lim  = cfg_data.value;
          REG_MAX_RANGE:   max_rng    = cfg_data.value;
          REG_WARN_LIMIT:  warn_lim   = cfg_data.value;
          REG_BLOCK_RUNS:  block_need = cfg_data.value[RUN_W-1:0];
          REG_CLEAR_RUNS:  clear_need = cfg_data.value[RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(qualify_reading(in_data.distance));
    end
    results_due = pending_results.size();
  end

endmodule

>>> bench/tb_sweep_range_qualifier_top.sv
// Testbench top for sweep_range_qualifier_top: directed and random readings
// under several register settings, random stalls on both channels.
// Depends on srq_pkg, srq_chan_if, the DUT and srq_checker.
module tb_sweep_range_qualifier_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srq_pkg::*;

  // kinds of reading the random part draws from
  typedef enum int {PICK_NEAR, PICK_GOOD, PICK_FAR, PICK_EDGE, PICK_NOISE} pick_t;

  logic        clk;
  logic        rst_n;
  bit          steady;       // no idling on either side while set
  int unsigned mismatches;
  int unsigned results_due;

  // local copy of the registers, used only to shape the stimulus
  logic [DIST_W-1:0] lim_close, lim_blind, lim_max, lim_warn;
  logic [RUN_W-1:0]  runs_block, runs_clear;

  srq_chan_if #(.payload_t(srq_in_t))  in_ch  ();
  srq_chan_if #(.payload_t(srq_out_t)) out_ch ();
  srq_chan_if #(.payload_t(srq_cfg_t)) cfg_ch ();

  sweep_range_qualifier_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  srq_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99, 0) < 35);
  endfunction

  // Result side: random backpressure, changed on the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !take_break();
    end
  end

  // Entered on a falling edge; returns on the falling edge after the beat with
  // valid still high, so back-to-back beats keep valid up.
  task automatic send_reading(logic [DIST_W-1:0] d);
    while (take_break()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.data.distance = d;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted beat has come back, then let
  // the pipeline settle before any register write.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [DIST_W-1:0] v);
    cfg_ch.data.index = r;
    cfg_ch.data.value = v;
    cfg_ch.valid      = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes all six registers; run counts carry random upper bits that the
  // block must drop.
  task automatic write_config(logic [DIST_W-1:0] c, logic [DIST_W-1:0] b,
                              logic [DIST_W-1:0] m, logic [DIST_W-1:0] w,
                              logic [RUN_W-1:0] nb, logic [RUN_W-1:0] nc);
    logic [DIST_W-RUN_W-1:0] junk;
    drain();
    write_reg(REG_CLOSE_LIMIT, c);
    write_reg(REG_BLIND_LIMIT, b);
    write_reg(REG_MAX_RANGE, m);
    write_reg(REG_WARN_LIMIT, w);
    junk = (DIST_W-RUN_W)'($urandom);
    write_reg(REG_BLOCK_RUNS, {junk, nb});
    junk = (DIST_W-RUN_W)'($urandom);
    write_reg(REG_CLEAR_RUNS, {junk, nc});
    cfg_ch.valid = 1'b0;
    lim_close  = c;
    lim_blind  = b;
    lim_max    = m;
    lim_warn   = w;
    runs_block = nb;
    runs_clear = nc;
  endtask

  function automatic logic [DIST_W-1:0] pick_distance(pick_t kind);
    int good_lo;
    // first distance that is neither close nor blind
    good_lo = (lim_close > lim_blind) ? int'(lim_close) : int'(lim_blind);
    case (kind)
      PICK_NEAR:
        return (good_lo == 0) ? '0 : DIST_W'($urandom_range(good_lo - 1, 0));
      PICK_GOOD:
        if (good_lo <= int'(lim_max))
          return DIST_W'($urandom_range(int'(lim_max), good_lo));
        else
          return DIST_W'($urandom_range(4095, good_lo));
      PICK_FAR:
        return (lim_max == '1) ? '1 : DIST_W'($urandom_range(4095, int'(lim_max) + 1));
      PICK_EDGE:
        // right on or just under one of the thresholds (just over for the range limit)
        case ($urandom_range(7, 0))
          0:       return lim_close;
          1:       return lim_close - 1'b1;
          2:       return lim_blind;
          3:       return lim_blind - 1'b1;
          4:       return lim_max;
          5:       return lim_max + 1'b1;
          6:       return lim_warn;
          default: return lim_warn - 1'b1;
        endcase
      default:
        return DIST_W'($urandom_range(4095, 0));
    endcase
  endfunction

  // Mostly runs of close or good readings long enough to set and clear the
  // blockage, mixed with out-of-range readings, threshold hits and noise.
  task automatic run_phase(int n);
    int    sent, burst;
    pick_t kind;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9, 0))
        0, 1, 2: begin
          kind  = PICK_NEAR;
          burst = $urandom_range(int'(runs_block) + 2, 1);
        end
        3, 4, 5: begin
          kind  = PICK_GOOD;
          burst = $urandom_range(int'(runs_clear) + 3, 1);
        end
        6: begin
          kind  = PICK_FAR;
          burst = $urandom_range(4, 1);
        end
        7: begin
          kind  = PICK_EDGE;
          burst = $urandom_range(3, 1);
        end
        default: begin
          kind  = PICK_NOISE;
          burst = $urandom_range(3, 1);
        end
      endcase
      repeat (burst) begin
        send_reading(pick_distance(kind));
        sent++;
      end
    end
  endtask

  task automatic random_config();
    logic [DIST_W-1:0] b, c, m, w;
    b = DIST_W'($urandom_range(200, 0));
    c = DIST_W'($urandom_range(400, 0));
    m = DIST_W'($urandom_range(4095, 800));
    w = DIST_W'($urandom_range(1200, 0));
    write_config(c, b, m, w, RUN_W'($urandom_range(6, 0)), RUN_W'($urandom_range(6, 0)));
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    steady       = 1'b0;
    lim_close    = CLOSE_LIMIT_RST;
    lim_blind    = BLIND_LIMIT_RST;
    lim_max      = MAX_RANGE_RST;
    lim_warn     = WARN_LIMIT_RST;
    runs_block   = BLOCK_RUNS_RST;
    runs_clear   = CLEAR_RUNS_RST;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // --- directed, reset settings ---
    send_reading(12'd2500);  // top of the valid band
    send_reading(12'd2501);  // just out of range, nothing stored yet
    send_reading(12'hFFF);   // saturated reading
    send_reading(12'd20);    // blind edge: valid but close, first close beat
    send_reading(12'd19);    // blind, second close beat
    send_reading(12'd79);    // third close beat sets the blockage
    send_reading(12'd80);    // good while blocked
    send_reading(12'd1);     // close while blocked restarts the good run
    send_reading(12'd300);
    send_reading(12'd299);
    send_reading(12'hFFF);   // third good beat clears, still ignored
    send_reading(12'd299);   // warning on a fresh reading
    send_reading(12'd300);
    send_reading(12'd0);     // no echo
    send_reading(12'hFFF);   // resets the close run, nothing stored here yet
    send_reading(12'hAAA);
    send_reading(12'h555);
    send_reading(12'h800);

    // zero run counts behave like one
    write_config(12'd80, 12'd20, 12'd2500, 12'd300, 4'd0, 4'd0);
    send_reading(12'd5);     // blocks at once
    send_reading(12'd5);
    send_reading(12'd1000);  // clears at once
    send_reading(12'd1000);

    // --- random phases; draining before each write also checks that the
    // sender can hold off until every result is back ---
    write_config(CLOSE_LIMIT_RST, BLIND_LIMIT_RST, MAX_RANGE_RST, WARN_LIMIT_RST,
                 BLOCK_RUNS_RST, CLEAR_RUNS_RST);
    run_phase(210);
    write_config('0, '0, '0, '0, '0, '0);              // lower extreme
    run_phase(210);
    write_config('1, '1, '1, '1, '1, '1);              // upper extreme
    run_phase(210);
    random_config();
    steady = 1'b1;                                     // full-rate stretch
    run_phase(210);
    steady = 1'b0;
    repeat (4) begin
      random_config();
      run_phase(210);
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/srq_pkg.sv
design/srq_chan_if.sv
design/sweep_range_qualifier_top.sv
design/srq_checker.sv
bench/srq_checker.sv
bench/tb_sweep_range_qualifier_top.sv
